>>> hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Immediate implication, sampled on clock, off while reset is high.
`define ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("implication check failed");

// Implication whose consequent must hold in the next cycle.
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

>>> hw/rtl/piota_pkg.sv
package piota_pkg;

   localparam logic [1:0] OP_CYCLE = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_WRITE = 2'd2;

   localparam logic [3:0] REG_ORB   = 4'd0;
   localparam logic [3:0] REG_ORA   = 4'd1;
   localparam logic [3:0] REG_DDRB  = 4'd2;
   localparam logic [3:0] REG_DDRA  = 4'd3;
   localparam logic [3:0] REG_T1CL  = 4'd4;
   localparam logic [3:0] REG_T1CH  = 4'd5;
   localparam logic [3:0] REG_T1LL  = 4'd6;
   localparam logic [3:0] REG_T1LH  = 4'd7;
   localparam logic [3:0] REG_T2CL  = 4'd8;
   localparam logic [3:0] REG_T2CH  = 4'd9;
   localparam logic [3:0] REG_SR    = 4'd10;
   localparam logic [3:0] REG_ACR   = 4'd11;
   localparam logic [3:0] REG_PCR   = 4'd12;
   localparam logic [3:0] REG_IFR   = 4'd13;
   localparam logic [3:0] REG_IER   = 4'd14;
   localparam logic [3:0] REG_ORA_NH = 4'd15;

   localparam logic [6:0] FLG_CA2 = 7'h01;
   localparam logic [6:0] FLG_CA1 = 7'h02;
   localparam logic [6:0] FLG_CB1 = 7'h10;
   localparam logic [6:0] FLG_T2  = 7'h20;
   localparam logic [6:0] FLG_T1  = 7'h40;

   localparam logic [15:0] TIMER_WRAP = 16'hFFFF;

endpackage

>>> hw/rtl/parallel_io_timer_interrupt_adapter.sv
// Pipeline: an accepted transfer passes through the input register, then the
// result register.
// Throughput: one item per cycle; a stalled result holds the input register,
// which then stalls the input side.
// Reset (synchronous, active high) clears all ports, timers, flags, enables,
// strobe and edge history to zero and empties both pipeline registers.
`include "assert_macros.svh"

module parallel_io_timer_interrupt_adapter import piota_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_operation,
   input  logic [3:0] req_reg_addr,
   input  logic [7:0] req_write_data,
   input  logic       req_side_effect,
   input  logic [7:0] req_port_a_in,
   input  logic [7:0] req_port_b_in,
   input  logic       req_ca1_pin,
   input  logic       req_count_pin,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_read_data,
   output logic       rsp_irq_out,
   output logic [7:0] rsp_port_a_out,
   output logic [7:0] rsp_port_a_dir,
   output logic [7:0] rsp_port_b_out,
   output logic [7:0] rsp_port_b_dir,
   output logic       rsp_pb7_timer_out,
   output logic       rsp_access_strobe
);

   // input register
   logic       s1_valid_ff, s1_valid_in;
   logic [1:0] s1_op_ff;
   logic [3:0] s1_addr_ff;
   logic [7:0] s1_data_ff;
   logic       s1_eff_ff;
   logic [7:0] s1_pa_ff, s1_pb_ff;
   logic       s1_ca1_ff, s1_cnt_ff;

   // block state
   logic [7:0]  pa_out_ff, pa_out_in, pb_out_ff, pb_out_in;
   logic [7:0]  pa_dir_ff, pa_dir_in, pb_dir_ff, pb_dir_in;
   logic [15:0] t1_cnt_ff, t1_cnt_in, t1_latch_ff, t1_latch_in;
   logic [15:0] t2_cnt_ff, t2_cnt_in, t2_latch_ff, t2_latch_in;
   logic        t1_act_ff, t1_act_in, t2_act_ff, t2_act_in;
   logic        t1_out_ff, t1_out_in;
   logic [7:0]  sr_ff, sr_in, acr_ff, acr_in, pcr_ff, pcr_in;
   logic [6:0]  flag_ff, flag_in, en_ff, en_in;
   logic        strobe_ff, strobe_in, strobe_phase_ff, strobe_phase_in;
   logic        prev_ca1_ff, prev_ca1_in, prev_cnt_ff, prev_cnt_in;

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_rd_ff, rsp_rd_in;
   logic       rsp_irq_ff;

   logic       advance;
   logic [7:0] pa_val, pb_val;
   logic       ca1_edge, count_rise;

   assign advance     = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready   = !s1_valid_ff || advance;
   assign s1_valid_in = req_ready ? req_valid : s1_valid_ff;
   assign rsp_valid_in = advance ? 1'b1 : (rsp_valid_ff && !rsp_ready);

   assign pa_val = (pa_out_ff & pa_dir_ff) | (s1_pa_ff & ~pa_dir_ff);
   always_comb begin
      pb_val = (pb_out_ff & pb_dir_ff) | (s1_pb_ff & ~pb_dir_ff);
      if (acr_ff[7]) begin
         pb_val[7] = t1_out_ff;
      end
   end

   assign ca1_edge = pcr_ff[0] ? (s1_ca1_ff && !prev_ca1_ff) : (!s1_ca1_ff && prev_ca1_ff);
   assign count_rise = s1_cnt_ff && !prev_cnt_ff;

   always_comb begin
      pa_out_in = pa_out_ff;
      pb_out_in = pb_out_ff;
      pa_dir_in = pa_dir_ff;
      pb_dir_in = pb_dir_ff;
      t1_cnt_in = t1_cnt_ff;
      t1_latch_in = t1_latch_ff;
      t2_cnt_in = t2_cnt_ff;
      t2_latch_in = t2_latch_ff;
      t1_act_in = t1_act_ff;
      t2_act_in = t2_act_ff;
      t1_out_in = t1_out_ff;
      sr_in = sr_ff;
      acr_in = acr_ff;
      pcr_in = pcr_ff;
      flag_in = flag_ff;
      en_in = en_ff;
      strobe_in = strobe_ff;
      strobe_phase_in = strobe_phase_ff;
      prev_ca1_in = prev_ca1_ff;
      prev_cnt_in = prev_cnt_ff;
      rsp_rd_in = 8'h00;

      if (advance) begin
         case (s1_op_ff)
            OP_CYCLE: begin
               // strobe lasts through the next cycle item; only count bit 0 matters
               strobe_in = strobe_ff & strobe_phase_ff;
               strobe_phase_in = ~strobe_phase_ff;
               if (ca1_edge) begin
                  flag_in = flag_in | FLG_CA1;
               end
               prev_ca1_in = s1_ca1_ff;
               prev_cnt_in = s1_cnt_ff;
               if (t1_act_ff) begin
                  if (t1_cnt_ff == 16'h0000) begin
                     t1_cnt_in = t1_latch_ff;
                     if (acr_ff[7]) begin
                        t1_out_in = acr_ff[6] ? ~t1_out_ff : 1'b1;
                     end
                     flag_in = flag_in | FLG_T1;
                     if (!acr_ff[6]) begin
                        t1_act_in = 1'b0;
                     end
                  end else begin
                     t1_cnt_in = t1_cnt_ff - 16'd1;
                  end
               end
               if (t2_act_ff && (!acr_ff[5] || count_rise)) begin
                  if (t2_cnt_ff == 16'h0000) begin
                     t2_cnt_in = TIMER_WRAP;
                     flag_in = flag_in | FLG_T2;
                     t2_act_in = 1'b0;
                  end else begin
                     t2_cnt_in = t2_cnt_ff - 16'd1;
                  end
               end
            end
            OP_READ: begin
               case (s1_addr_ff)
                  REG_ORB: begin
                     rsp_rd_in = pb_val;
                     if (s1_eff_ff) begin
                        flag_in = flag_ff & ~FLG_CB1;
                        strobe_in = 1'b1;
                        strobe_phase_in = 1'b1;
                     end
                  end
                  REG_ORA: begin
                     rsp_rd_in = pa_val;
                     if (s1_eff_ff) begin
                        flag_in = flag_ff & ~(FLG_CA1 | FLG_CA2);
                     end
                  end
                  REG_DDRB: rsp_rd_in = pb_dir_ff;
                  REG_DDRA: rsp_rd_in = pa_dir_ff;
                  REG_T1CL: begin
                     rsp_rd_in = t1_cnt_ff[7:0];
                     if (s1_eff_ff) begin
                        flag_in = flag_ff & ~FLG_T1;
                     end
                  end
                  REG_T1CH: rsp_rd_in = t1_cnt_ff[15:8];
                  REG_T1LL: rsp_rd_in = t1_latch_ff[7:0];
                  REG_T1LH: rsp_rd_in = t1_latch_ff[15:8];
                  REG_T2CL: begin
                     rsp_rd_in = t2_cnt_ff[7:0];
                     if (s1_eff_ff) begin
                        flag_in = flag_ff & ~FLG_T2;
                     end
                  end
                  REG_T2CH: rsp_rd_in = t2_cnt_ff[15:8];
                  REG_SR:   rsp_rd_in = sr_ff;
                  REG_ACR:  rsp_rd_in = acr_ff;
                  REG_PCR:  rsp_rd_in = pcr_ff;
                  REG_IFR:  rsp_rd_in = {|(flag_ff & en_ff), flag_ff};
                  REG_IER:  rsp_rd_in = {1'b1, en_ff};
                  default: begin
                     rsp_rd_in = pa_val;
                     if (s1_eff_ff) begin
                        flag_in = flag_ff & ~FLG_CA1;
                     end
                  end
               endcase
            end
            OP_WRITE: begin
               case (s1_addr_ff)
                  REG_ORB: begin
                     pb_out_in = s1_data_ff;
                     strobe_in = 1'b1;
                     strobe_phase_in = 1'b1;
                  end
                  REG_ORA, REG_ORA_NH: pa_out_in = s1_data_ff;
                  REG_DDRB: pb_dir_in = s1_data_ff;
                  REG_DDRA: pa_dir_in = s1_data_ff;
                  REG_T1CL, REG_T1LL: t1_latch_in = {t1_latch_ff[15:8], s1_data_ff};
                  REG_T1CH: begin
                     t1_latch_in = {s1_data_ff, t1_latch_ff[7:0]};
                     t1_cnt_in = {s1_data_ff, t1_latch_ff[7:0]};
                     if (acr_ff[7]) begin
                        t1_out_in = 1'b0;
                     end
                     t1_act_in = 1'b1;
                     flag_in = flag_ff & ~FLG_T1;
                  end
                  REG_T1LH: t1_latch_in = {s1_data_ff, t1_latch_ff[7:0]};
                  REG_T2CL: t2_latch_in = {t2_latch_ff[15:8], s1_data_ff};
                  REG_T2CH: begin
                     t2_latch_in = {s1_data_ff, t2_latch_ff[7:0]};
                     t2_cnt_in = {s1_data_ff, t2_latch_ff[7:0]};
                     t2_act_in = 1'b1;
                     flag_in = flag_ff & ~FLG_T2;
                  end
                  REG_SR:  sr_in = s1_data_ff;
                  REG_ACR: acr_in = s1_data_ff;
                  REG_PCR: pcr_in = s1_data_ff;
                  REG_IFR: flag_in = flag_ff & ~s1_data_ff[6:0];
                  default: begin
                     if (s1_data_ff[7]) begin
                        en_in = en_ff | s1_data_ff[6:0];
                     end else begin
                        en_in = en_ff & ~s1_data_ff[6:0];
                     end
                  end
               endcase
            end
            default: begin
               rsp_rd_in = 8'h00;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready) begin
         s1_op_ff   <= req_operation;
         s1_addr_ff <= req_reg_addr;
         s1_data_ff <= req_write_data;
         s1_eff_ff  <= req_side_effect;
         s1_pa_ff   <= req_port_a_in;
         s1_pb_ff   <= req_port_b_in;
         s1_ca1_ff  <= req_ca1_pin;
         s1_cnt_ff  <= req_count_pin;
      end
      if (advance) begin
         rsp_rd_ff  <= rsp_rd_in;
         rsp_irq_ff <= |(flag_in & en_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pa_out_ff <= '0;
         pb_out_ff <= '0;
         pa_dir_ff <= '0;
         pb_dir_ff <= '0;
         t1_cnt_ff <= '0;
         t1_latch_ff <= '0;
         t2_cnt_ff <= '0;
         t2_latch_ff <= '0;
         t1_act_ff <= 1'b0;
         t2_act_ff <= 1'b0;
         t1_out_ff <= 1'b0;
         sr_ff <= '0;
         acr_ff <= '0;
         pcr_ff <= '0;
         flag_ff <= '0;
         en_ff <= '0;
         strobe_ff <= 1'b0;
         strobe_phase_ff <= 1'b0;
         prev_ca1_ff <= 1'b0;
         prev_cnt_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         pa_out_ff <= pa_out_in;
         pb_out_ff <= pb_out_in;
         pa_dir_ff <= pa_dir_in;
         pb_dir_ff <= pb_dir_in;
         t1_cnt_ff <= t1_cnt_in;
         t1_latch_ff <= t1_latch_in;
         t2_cnt_ff <= t2_cnt_in;
         t2_latch_ff <= t2_latch_in;
         t1_act_ff <= t1_act_in;
         t2_act_ff <= t2_act_in;
         t1_out_ff <= t1_out_in;
         sr_ff <= sr_in;
         acr_ff <= acr_in;
         pcr_ff <= pcr_in;
         flag_ff <= flag_in;
         en_ff <= en_in;
         strobe_ff <= strobe_in;
         strobe_phase_ff <= strobe_phase_in;
         prev_ca1_ff <= prev_ca1_in;
         prev_cnt_ff <= prev_cnt_in;
      end
   end

   // port, timer-out and strobe results mirror state once the transfer is done
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_read_data     = rsp_rd_ff;
   assign rsp_irq_out       = rsp_irq_ff;
   assign rsp_port_a_out    = pa_out_ff;
   assign rsp_port_a_dir    = pa_dir_ff;
   assign rsp_port_b_out    = pb_out_ff;
   assign rsp_port_b_dir    = pb_dir_ff;
   assign rsp_pb7_timer_out = t1_out_ff;
   assign rsp_access_strobe = strobe_ff;

   `ASSERT_IMPLIES(a_irq_matches_state, rsp_valid_ff, rsp_irq_ff == |(flag_ff & en_ff))
   `ASSERT_IMPLIES(a_empty_takes_input, !s1_valid_ff, req_ready)
   `ASSERT_NEXT(a_stall_keeps_item, s1_valid_ff && !advance, s1_valid_ff)
   `ASSERT_NEXT(a_t2_expiry_flags, advance && s1_op_ff == OP_CYCLE && t2_act_ff &&
      !acr_ff[5] && t2_cnt_ff == 16'h0000, !t2_act_ff && flag_ff[5])

endmodule
